[hdl/shs_pkg.sv]
`timescale 1ns / 1ps

package shs_pkg;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic        fin;
		logic        restart;
		logic [2:0]  nbytes;
		logic [31:0] word;
		logic [63:0] bit_count;
	} shs_entry_t;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

[hdl/shs_in_if.sv]
`timescale 1ns / 1ps

interface shs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       empty_message;

	modport source(output valid, data_byte, last_byte, empty_message, input ready);
	modport sink(input valid, data_byte, last_byte, empty_message, output ready);
endinterface

[hdl/shs_out_if.sv]
`timescale 1ns / 1ps

interface shs_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source(output valid, digest_word, word_index, last_word, input ready);
	modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

[hdl/shs_front.sv]
`timescale 1ns / 1ps

module shs_front (
	input  logic                clk,
	input  logic                arst_n,
	shs_in_if.sink              msg,
	input  logic                q_full,
	output logic                push,
	output shs_pkg::shs_entry_t push_entry
);

	logic [1:0]  nb_q;
	logic [31:0] acc_q;
	logic [63:0] bits_q;
	logic        accept;
	logic [31:0] merged;
	logic [63:0] bits_nx;

	assign msg.ready = !q_full;
	assign accept    = msg.valid && msg.ready;
	assign merged    = acc_q | ({24'b0, msg.data_byte} << {~nb_q, 3'b000});
	assign bits_nx   = bits_q + 64'd8;

	always_comb begin
		push_entry = '0;
		if (msg.empty_message) begin
			push_entry.fin     = 1'b1;
			push_entry.restart = 1'b1;
		end else if (msg.last_byte) begin
			push_entry.fin       = 1'b1;
			push_entry.nbytes    = {1'b0, nb_q} + 3'd1;
			push_entry.word      = merged;
			push_entry.bit_count = bits_nx;
		end else begin
			push_entry.word = merged;
		end
		push = accept && (msg.empty_message || msg.last_byte || nb_q == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_q   <= '0;
			acc_q  <= '0;
			bits_q <= '0;
		end else if (accept) begin
			if (msg.empty_message || msg.last_byte) begin
				nb_q   <= '0;
				acc_q  <= '0;
				bits_q <= '0;
			end else begin
				nb_q   <= nb_q + 2'd1;
				acc_q  <= (nb_q == 2'd3) ? 32'h0 : merged;
				bits_q <= bits_nx;
			end
		end
	end

endmodule

[hdl/shs_queue.sv]
`timescale 1ns / 1ps

module shs_queue #(
	parameter int DEPTH = shs_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  shs_pkg::shs_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                valid,
	output shs_pkg::shs_entry_t pop_entry
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	shs_pkg::shs_entry_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          wr;
	logic          rd;

	assign full      = (count_q == CW'(DEPTH));
	assign valid     = (count_q != '0);
	assign wr        = push && !full;
	assign rd        = pop && valid;
	assign pop_entry = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/shs_engine.sv]
`timescale 1ns / 1ps

module shs_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  shs_pkg::shs_entry_t q_entry,
	output logic                pop,
	shs_out_if.source           digest
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PAD,
		ST_COMP,
		ST_ADD,
		ST_OUT
	} state_t;

	state_t      state_q;
	logic [31:0] win_q  [16];
	logic [31:0] hash_q [8];
	logic [31:0] work_q [8];
	logic [3:0]  cnt_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic [2:0]  nb_q;
	logic [31:0] word_q;
	logic [63:0] len_q;
	logic        marker_q;
	logic        lenhi_q;
	logic        ret_pad_q;
	logic        final_q;

	logic        push_en;
	logic [31:0] push_w;
	logic        push_last;
	logic        block_full;
	logic [31:0] new_w;
	logic [31:0] t1;
	logic [31:0] t2;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	assign pop = (state_q == ST_LOAD) && q_valid;

	always_comb begin
		push_en   = 1'b0;
		push_w    = 32'h0;
		push_last = 1'b0;
		case (state_q)
			ST_LOAD: begin
				push_en = pop && !q_entry.fin;
				push_w  = q_entry.word;
			end
			ST_PAD: begin
				push_en = 1'b1;
				if (!marker_q) begin
					push_w = (nb_q == 3'd4) ? word_q :
						(word_q | (32'h8000_0000 >> {nb_q[1:0], 3'b000}));
				end else if (!lenhi_q && cnt_q != 4'd14) begin
					push_w = 32'h0;
				end else if (!lenhi_q) begin
					push_w = len_q[63:32];
				end else begin
					push_w    = len_q[31:0];
					push_last = 1'b1;
				end
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
		block_full = push_en && (cnt_q == 4'd15);
	end

	always_comb begin
		new_w = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
		t1 = work_q[7] + bsig1(work_q[4])
			+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
			+ shs_pkg::round_k(rnd_q) + win_q[0];
		t2 = bsig0(work_q[0])
			+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
	end

	assign digest.valid       = (state_q == ST_OUT);
	assign digest.digest_word = hash_q[idx_q];
	assign digest.word_index  = idx_q;
	assign digest.last_word   = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			win_q     <= '{default: '0};
			hash_q    <= shs_pkg::INIT_HASH;
			work_q    <= '{default: '0};
			cnt_q     <= '0;
			rnd_q     <= '0;
			idx_q     <= '0;
			nb_q      <= '0;
			word_q    <= '0;
			len_q     <= '0;
			marker_q  <= 1'b0;
			lenhi_q   <= 1'b0;
			ret_pad_q <= 1'b0;
			final_q   <= 1'b0;
		end else begin
			if (push_en) begin
				for (int i = 0; i < 15; i++) begin
					win_q[i] <= win_q[i + 1];
				end
				win_q[15] <= push_w;
				cnt_q     <= cnt_q + 4'd1;
			end
			case (state_q)
				ST_LOAD: begin
					if (pop && q_entry.fin) begin
						nb_q     <= q_entry.nbytes;
						word_q   <= q_entry.word;
						len_q    <= q_entry.bit_count;
						marker_q <= 1'b0;
						lenhi_q  <= 1'b0;
						state_q  <= ST_PAD;
						if (q_entry.restart) begin
							cnt_q  <= '0;
							hash_q <= shs_pkg::INIT_HASH;
						end
					end else if (block_full) begin
						work_q    <= hash_q;
						rnd_q     <= '0;
						ret_pad_q <= 1'b0;
						final_q   <= 1'b0;
						state_q   <= ST_COMP;
					end
				end
				ST_PAD: begin
					if (!marker_q) begin
						if (nb_q == 3'd4) begin
							nb_q   <= '0;
							word_q <= '0;
						end else begin
							marker_q <= 1'b1;
						end
					end else if (!lenhi_q && cnt_q == 4'd14) begin
						lenhi_q <= 1'b1;
					end
					if (block_full) begin
						work_q    <= hash_q;
						rnd_q     <= '0;
						ret_pad_q <= 1'b1;
						final_q   <= push_last;
						state_q   <= ST_COMP;
					end
				end
				ST_COMP: begin
					work_q[1] <= work_q[0];
					work_q[2] <= work_q[1];
					work_q[3] <= work_q[2];
					work_q[5] <= work_q[4];
					work_q[6] <= work_q[5];
					work_q[7] <= work_q[6];
					work_q[4] <= work_q[3] + t1;
					work_q[0] <= t1 + t2;
					for (int i = 0; i < 15; i++) begin
						win_q[i] <= win_q[i + 1];
					end
					win_q[15] <= new_w;
					rnd_q     <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + work_q[i];
					end
					idx_q <= '0;
					if (final_q) begin
						state_q <= ST_OUT;
					end else if (ret_pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_OUT: begin
					if (digest.ready) begin
						if (idx_q == 3'd7) begin
							hash_q  <= shs_pkg::INIT_HASH;
							idx_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

[hdl/sha256_stream_hasher_core.sv]
`timescale 1ns / 1ps
// SHA-256 hasher for a byte stream.
// msg: one beat per message byte; last_byte closes the message, empty_message
//   asks for the digest of the zero-length message and drops any open message.
// digest: eight beats per message, word_index 0 (most significant) to 7, with
//   last_word on word 7.
// The front packs bytes into 32-bit words and takes one beat per cycle while
// the word queue has room. The back loads 16 words into the schedule window,
// then runs 64 rounds, one per cycle, and one hash add. With the default
// four-word queue, the queue soaks up 16 bytes while the back compresses.
// After the closing beat the back pads one word per cycle up to the end of the
// block and compresses it; when the length does not fit, a second block of
// padding follows and is compressed as well.
// While the receiver stalls, the digest word holds and the back takes no more
// words; the front keeps taking bytes until the queue is full.
// Reset clears the queue, the byte count and loads the initial hash values.
module sha256_stream_hasher_core #(
	parameter int QUEUE_DEPTH = shs_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	shs_in_if.sink    msg,
	shs_out_if.source digest
);

	shs_pkg::shs_entry_t push_entry;
	shs_pkg::shs_entry_t pop_entry;
	logic                q_push;
	logic                q_full;
	logic                q_pop;
	logic                q_valid;

	shs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.q_full     (q_full),
		.push       (q_push),
		.push_entry (push_entry)
	);

	shs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.valid      (q_valid),
		.pop_entry  (pop_entry)
	);

	shs_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (pop_entry),
		.pop     (q_pop),
		.digest  (digest)
	);

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("word pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("queue popped while empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		(digest.valid && digest.ready && digest.last_word) |=> !digest.valid)
		else $error("digest still shown after its last word");
`endif

endmodule

[tb/tb_sha256_stream_hasher_core.sv]
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_core;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_ITEMS  = 320;
	localparam int END_DRAIN   = 400;
	localparam int DIR_ROWS    = 12;

	localparam logic [255:0] DIG_EMPTY =
		256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
	localparam logic [255:0] DIG_ABC =
		256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

	localparam logic [31:0] IV_WORDS [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam int SPECIAL_LEN [6] = '{55, 56, 57, 63, 64, 65};
	localparam int SEND_IDLE_PCT [3] = '{36, 65, 0};
	localparam int RECV_STALL_PCT [3] = '{65, 36, 0};

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	typedef struct packed {
		logic [7:0]   data;
		logic         last;
		logic         empty;
		logic         typed;
		logic [255:0] dig;
	} msg_row_t;

	logic clk;
	logic arst_n;
	int   phase;
	int   cycle_cnt;
	int   fails;

	logic [31:0] hv [8];
	logic [7:0]  blk [64];
	int          fill;
	logic [63:0] nbits;
	logic [31:0] fresh_digest [8];

	digest_beat_t digest_exp [$];
	msg_row_t     dir_rows [DIR_ROWS];

	shs_in_if  msg_if();
	shs_out_if dig_if();

	sha256_stream_hasher_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg_if),
		.digest(dig_if)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic sha_compress;
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, ch, mj, t1, t2;
		int t, j;
		for (t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		for (t = 16; t < 64; t++) begin
			s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		for (j = 0; j < 8; j++)
			v[j] = hv[j];
		for (t = 0; t < 64; t++) begin
			s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			t1 = v[7] + s1 + ch + RK[t] + w[t];
			s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
			mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t2 = s0 + mj;
			for (j = 7; j > 0; j--)
				v[j] = v[j-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (j = 0; j < 8; j++)
			hv[j] = hv[j] + v[j];
	endtask

	task automatic clear_hash_state;
		int j;
		for (j = 0; j < 8; j++)
			hv[j] = IV_WORDS[j];
		fill = 0;
		nbits = '0;
	endtask

	task automatic seal_message;
		int p, j;
		p = fill;
		blk[p] = 8'h80;
		p++;
		if (p > 56) begin
			while (p < 64) begin
				blk[p] = 8'h00;
				p++;
			end
			sha_compress();
			p = 0;
		end
		while (p < 56) begin
			blk[p] = 8'h00;
			p++;
		end
		for (j = 0; j < 8; j++)
			blk[56+j] = nbits[63-8*j -: 8];
		sha_compress();
		for (j = 0; j < 8; j++)
			fresh_digest[j] = hv[j];
		clear_hash_state();
	endtask

	task automatic hash_step(input logic [7:0] d, input logic l, input logic e,
			output bit produced);
		produced = 1'b0;
		if (e) begin
			clear_hash_state();
			seal_message();
			produced = 1'b1;
		end else begin
			blk[fill] = d;
			nbits = nbits + 64'd8;
			if (fill == 63) begin
				sha_compress();
				fill = 0;
			end else begin
				fill++;
			end
			if (l) begin
				seal_message();
				produced = 1'b1;
			end
		end
	endtask

	task automatic send_beat(input logic [7:0] d, input logic l, input logic e,
			input logic typed, input logic [255:0] dig);
		bit produced;
		int j;
		digest_beat_t b;
		while ($urandom_range(0, 99) < SEND_IDLE_PCT[phase]) begin
			msg_if.valid <= 1'b0;
			@(negedge clk);
		end
		msg_if.valid         <= 1'b1;
		msg_if.data_byte     <= d;
		msg_if.last_byte     <= l;
		msg_if.empty_message <= e;
		@(posedge clk);
		while (!msg_if.ready)
			@(posedge clk);
		hash_step(d, l, e, produced);
		if (produced) begin
			for (j = 0; j < 8; j++) begin
				b.word = typed ? dig[255-32*j -: 32] : fresh_digest[j];
				b.idx  = j[2:0];
				b.last = (j == 7);
				digest_exp.push_back(b);
			end
		end
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n)
			dig_if.ready <= 1'b0;
		else
			dig_if.ready <= ($urandom_range(0, 99) >= RECV_STALL_PCT[phase]);
	end

	always @(posedge clk) begin : digest_check
		digest_beat_t want;
		if (arst_n && dig_if.valid && dig_if.ready) begin
			if (digest_exp.size() == 0) begin
				$display("%0t: unexpected digest beat: expected none, actual %h idx %0d last %0b",
					$time, dig_if.digest_word, dig_if.word_index, dig_if.last_word);
				fails++;
			end else begin
				want = digest_exp.pop_front();
				if (dig_if.digest_word !== want.word) begin
					$display("%0t: digest_word mismatch: expected %h, actual %h",
						$time, want.word, dig_if.digest_word);
					fails++;
				end
				if (dig_if.word_index !== want.idx) begin
					$display("%0t: word_index mismatch: expected %0d, actual %0d",
						$time, want.idx, dig_if.word_index);
					fails++;
				end
				if (dig_if.last_word !== want.last) begin
					$display("%0t: last_word mismatch: expected %0b, actual %0b",
						$time, want.last, dig_if.last_word);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int sent, len, cut, k, r;
		dir_rows = '{
			'{8'hff, 1'b1, 1'b1, 1'b1, DIG_EMPTY},
			'{8'h61, 1'b0, 1'b0, 1'b0, 256'h0},
			'{8'h62, 1'b0, 1'b0, 1'b0, 256'h0},
			'{8'h63, 1'b1, 1'b0, 1'b1, DIG_ABC},
			'{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
			'{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
			'{8'h00, 1'b0, 1'b1, 1'b1, DIG_EMPTY},
			'{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
			'{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
			'{8'h80, 1'b0, 1'b0, 1'b0, 256'h0},
			'{8'h7f, 1'b1, 1'b0, 1'b0, 256'h0},
			'{8'h00, 1'b0, 1'b1, 1'b1, DIG_EMPTY}
		};
		phase = 0;
		cycle_cnt = 0;
		fails = 0;
		arst_n = 1'b0;
		msg_if.valid = 1'b0;
		msg_if.data_byte = 8'h00;
		msg_if.last_byte = 1'b0;
		msg_if.empty_message = 1'b0;
		dig_if.ready = 1'b0;
		clear_hash_state();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < DIR_ROWS; k++)
			send_beat(dir_rows[k].data, dir_rows[k].last, dir_rows[k].empty,
				dir_rows[k].typed, dir_rows[k].dig);

		// hold until the directed digests are all out
		msg_if.valid <= 1'b0;
		@(negedge clk);
		while (digest_exp.size() != 0)
			@(negedge clk);

		sent = 0;
		while (sent < RAND_ITEMS) begin
			phase = (sent * 3) / RAND_ITEMS;
			if ($urandom_range(0, 7) == 0) begin
				while (digest_exp.size() != 0) begin
					msg_if.valid <= 1'b0;
					@(negedge clk);
				end
			end
			r = $urandom_range(0, 9);
			if (r == 0) begin
				send_beat(8'($urandom), 1'($urandom), 1'b1, 1'b0, 256'h0);
				sent++;
			end else begin
				if ($urandom_range(0, 3) == 0)
					len = SPECIAL_LEN[$urandom_range(0, 5)];
				else
					len = $urandom_range(1, 24);
				cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len;
				for (k = 0; k < cut; k++) begin
					phase = (sent * 3) / RAND_ITEMS;
					send_beat(8'($urandom), (k == len - 1), 1'b0, 1'b0, 256'h0);
					sent++;
				end
				// drop the open message with an empty request
				if (cut < len) begin
					send_beat(8'($urandom), 1'($urandom), 1'b1, 1'b0, 256'h0);
					sent++;
				end
			end
		end
		phase = 2;
		msg_if.valid <= 1'b0;

		while (digest_exp.size() != 0)
			@(posedge clk);
		repeat (END_DRAIN) @(posedge clk);
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[files.f]
hdl/shs_pkg.sv
hdl/shs_in_if.sv
hdl/shs_out_if.sv
hdl/shs_front.sv
hdl/shs_queue.sv
hdl/shs_engine.sv
hdl/sha256_stream_hasher_core.sv
tb/tb_sha256_stream_hasher_core.sv
